[hw/rtl/fsmask_pkg.sv]
// Shared types, codes and helpers for the feature spacing mask block.
package fsmask_pkg;

	localparam int COORD_W = 12;   // clipped pixel coordinate, covers the largest image
	localparam int CMP_W   = 15;   // signed width for box and border arithmetic
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int WORD_W  = 64;
	localparam int WORD_SH = 6;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_OLD   = 2'd1,
		KIND_CAND  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT  = 2'd0,
		VERDICT_BORDER  = 2'd1,
		VERDICT_BLOCKED = 2'd2,
		VERDICT_DONE    = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		REG_COLUMNS = 2'd0,
		REG_ROWS    = 2'd1,
		REG_HALF    = 2'd2,
		REG_MARGIN  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_CLEAR,
		BK_CHECK,
		BK_BOX,
		BK_DRAIN
	} back_state_t;

	typedef struct packed {
		logic [10:0] cols;
		logic [10:0] rows;
		logic [4:0]  half;
		logic [8:0]  margin;
	} cfg_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		kind_t              op;
		logic               outside;
		logic               empty;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [COORD_W-1:0] c0;
		logic [COORD_W-1:0] c1;
		logic [COORD_W-1:0] r0;
		logic [COORD_W-1:0] r1;
	} cmd_t;

	// Round a q4 value to whole pixels, halves away from zero.
	function automatic logic signed [COORD_W-1:0] q4_round(input logic [14:0] v);
		logic [14:0]        mag;
		logic [15:0]        sum;
		logic [COORD_W-1:0] r;
		mag = v[14] ? (~v + 15'd1) : v;
		sum = {1'b0, mag} + 16'd8;
		r = sum[15:4];
		q4_round = v[14] ? signed'(~r + COORD_W'(1)) : signed'(r);
	endfunction

endpackage

[hw/rtl/fsmask_if.sv]
// Item and verdict channel interfaces.
interface fsmask_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [14:0] x_q4;
	logic signed [14:0] y_q4;

	modport source(output valid, output kind, output x_q4, output y_q4, input ready);
	modport sink(input valid, input kind, input x_q4, input y_q4, output ready);
endinterface

interface fsmask_verdict_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source(output valid, output verdict, input ready);
	modport sink(input valid, input verdict, output ready);
endinterface

[hw/rtl/fsmask_front.sv]
// Front end: takes items, rounds coordinates, clips the box and runs the border test.
module fsmask_front import fsmask_pkg::*; #(
	parameter int MAX_COLUMNS     = 1024,
	parameter int MAX_ROWS        = 1024,
	parameter int MAX_HALF_LENGTH = 31
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   hold,
	fsmask_item_if.sink items,
	input  cfg_t   cfg,
	input  logic   q_full,
	output logic   push,
	output cmd_t   push_cmd
);

	localparam logic signed [CMP_W-1:0] MAX_C = CMP_W'(MAX_COLUMNS);
	localparam logic signed [CMP_W-1:0] MAX_R = CMP_W'(MAX_ROWS);
	localparam logic signed [CMP_W-1:0] MAX_H = CMP_W'(MAX_HALF_LENGTH);
	localparam logic signed [CMP_W-1:0] ONE   = CMP_W'(1);

	logic                      valid_s1;
	kind_t                     kind_s1;
	logic signed [COORD_W-1:0] x_s1;
	logic signed [COORD_W-1:0] y_s1;

	logic signed [CMP_W-1:0] xs, ys, hs, ms;
	logic signed [CMP_W-1:0] cols_raw, rows_raw, cols, rows;
	logic signed [CMP_W-1:0] xmax, ymax, c0, c1, r0, r1;

	assign push = valid_s1 && !q_full;
	assign items.ready = !hold && (!valid_s1 || !q_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			kind_s1 <= kind_t'(items.kind);
			x_s1 <= q4_round(items.x_q4);
			y_s1 <= q4_round(items.y_q4);
		end
	end

	always_comb begin
		xs = {{(CMP_W-COORD_W){x_s1[COORD_W-1]}}, x_s1};
		ys = {{(CMP_W-COORD_W){y_s1[COORD_W-1]}}, y_s1};
		hs = (CMP_W'(cfg.half) > MAX_H) ? MAX_H : CMP_W'(cfg.half);
		ms = CMP_W'(cfg.margin);
		cols_raw = CMP_W'(cfg.cols);
		rows_raw = CMP_W'(cfg.rows);
		cols = (cols_raw == '0) ? ONE : ((cols_raw > MAX_C) ? MAX_C : cols_raw);
		rows = (rows_raw == '0) ? ONE : ((rows_raw > MAX_R) ? MAX_R : rows_raw);
		xmax = cols - ms - ONE;
		ymax = rows - ms - ONE;
		c0 = xs - hs;
		c1 = xs + hs;
		r0 = ys - hs;
		r1 = ys + hs;
		if (c0[CMP_W-1]) c0 = '0;
		if (r0[CMP_W-1]) r0 = '0;
		if (c1 > cols - ONE) c1 = cols - ONE;
		if (r1 > rows - ONE) r1 = rows - ONE;

		push_cmd.op = kind_s1;
		push_cmd.outside = (xs < ms) || (xs > xmax) || (ys < ms) || (ys > ymax);
		push_cmd.empty = (c0 > c1) || (r0 > r1);
		push_cmd.px = xs[COORD_W-1:0];
		push_cmd.py = ys[COORD_W-1:0];
		push_cmd.c0 = c0[COORD_W-1:0];
		push_cmd.c1 = c1[COORD_W-1:0];
		push_cmd.r0 = r0[COORD_W-1:0];
		push_cmd.r1 = r1[COORD_W-1:0];
	end

endmodule

[hw/rtl/fsmask_queue.sv]
// Two-entry command queue between front and back.
module fsmask_queue import fsmask_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int DEPTH = 2;

	cmd_t       slot_q [DEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full = count_q == 2'(DEPTH);
	assign empty = count_q == 2'd0;
	assign head = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_cmd;
	end

endmodule

[hw/rtl/fsmask_back.sv]
// Back end: owns the occupancy mask, clears it, probes candidates and sets boxes.
module fsmask_back import fsmask_pkg::*; #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_empty,
	input  cmd_t     q_head,
	output logic     q_pop,
	input  logic     out_free,
	output logic     emit,
	output verdict_t emit_verdict,
	output logic     init_busy
);

	localparam int WPR   = (MAX_COLUMNS + WORD_W - 1) / WORD_W;
	localparam int DEPTH = WPR * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [AW-1:0] ROW_STEP  = AW'(WPR);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	back_state_t state_q, state_d;

	logic [COORD_W-1:0] row_q, r1_q;
	logic [AW-1:0]      base_q, w0_q, w1_q;
	logic               two_q, second_q;
	logic [WORD_W-1:0]  mask0_q, mask1_q;
	logic [WORD_SH-1:0] bit_q;
	logic [AW-1:0]      clr_q;

	logic              wr_pend_s1;
	logic [AW-1:0]     wr_addr_s1;
	logic [WORD_W-1:0] wr_mask_s1;

	logic              cand_in, head_ready, load, re, clr_we, row_done;
	logic [AW-1:0]     raddr, probe_addr, box_addr, head_base, head_w0, head_w1;
	logic [WORD_W-1:0] lmask, hmask;

	assign cand_in = (q_head.op == KIND_CAND) && !q_head.outside;
	assign head_ready = !q_empty && (cand_in || out_free);

	assign head_base = AW'(q_head.r0 * WPR);
	assign head_w0 = AW'(q_head.c0 >> WORD_SH);
	assign head_w1 = AW'(q_head.c1 >> WORD_SH);
	assign probe_addr = AW'(q_head.py * WPR) + AW'(q_head.px >> WORD_SH);
	assign lmask = {WORD_W{1'b1}} << q_head.c0[WORD_SH-1:0];
	assign hmask = {WORD_W{1'b1}} >> (~q_head.c1[WORD_SH-1:0]);
	assign box_addr = base_q + (second_q ? w1_q : w0_q);
	assign row_done = !two_q || second_q;
	assign init_busy = state_q == BK_INIT;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_INIT, BK_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (head_ready) begin
					case (q_head.op)
						KIND_CAND: state_d = q_head.outside ? BK_IDLE : BK_CHECK;
						KIND_CLEAR: state_d = BK_CLEAR;
						KIND_OLD: state_d = q_head.empty ? BK_IDLE : BK_BOX;
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_CHECK: begin
				if (out_free) state_d = rdata_q[bit_q] ? BK_IDLE : BK_BOX;
			end
			BK_BOX: begin
				if (row_done && row_q == r1_q) state_d = BK_DRAIN;
			end
			BK_DRAIN: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		emit = 1'b0;
		emit_verdict = VERDICT_DONE;
		re = 1'b0;
		raddr = box_addr;
		load = 1'b0;
		clr_we = 1'b0;
		case (state_q)
			BK_INIT, BK_CLEAR: clr_we = 1'b1;
			BK_IDLE: begin
				q_pop = head_ready;
				load = head_ready;
				emit = head_ready && !cand_in;
				emit_verdict = (q_head.op == KIND_CAND) ? VERDICT_BORDER : VERDICT_DONE;
				re = head_ready && cand_in;
				raddr = probe_addr;
			end
			BK_CHECK: begin
				emit = out_free;
				emit_verdict = rdata_q[bit_q] ? VERDICT_BLOCKED : VERDICT_ACCEPT;
			end
			BK_BOX: re = 1'b1;
			default: ;
		endcase
	end

	// Write port serves the clear sweep or the pending box write; read data is registered.
	always_ff @(posedge clk) begin
		if (clr_we) mem[clr_q] <= '0;
		else if (wr_pend_s1) mem[wr_addr_s1] <= rdata_q | wr_mask_s1;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_INIT;
			clr_q <= '0;
			wr_pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_pend_s1 <= state_q == BK_BOX;
			if (clr_we) clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= box_addr;
		wr_mask_s1 <= second_q ? mask1_q : mask0_q;
		if (load) begin
			row_q <= q_head.r0;
			r1_q <= q_head.r1;
			base_q <= head_base;
			w0_q <= head_w0;
			w1_q <= head_w1;
			two_q <= head_w0 != head_w1;
			second_q <= 1'b0;
			mask0_q <= (head_w0 != head_w1) ? lmask : (lmask & hmask);
			mask1_q <= hmask;
			bit_q <= q_head.px[WORD_SH-1:0];
		end else if (state_q == BK_BOX) begin
			if (!row_done) begin
				second_q <= 1'b1;
			end else begin
				second_q <= 1'b0;
				row_q <= row_q + COORD_W'(1);
				base_q <= base_q + ROW_STEP;
			end
		end
	end

endmodule

[hw/rtl/feature_spacing_mask.sv]
// Verdicts: a clear, an old feature or a candidate outside the border is answered in the back's
// idle state, a probed candidate in the check state after its mask read; the verdict register
// then waits for the taker. Throughput: one item per cycle unless the queue, the taker, or a
// probe or box write in the back holds the flow; a box is set one mask word at a time, and a
// frame clear sweeps all MAX_ROWS*ceil(MAX_COLUMNS/64) mask words. Reset: registers return to
// 640x480, half 5, margin 0; no item is taken until the mask is cleared (16384 words at the defaults).
module feature_spacing_mask import fsmask_pkg::*; #(
	parameter int MAX_COLUMNS     = 1024,
	parameter int MAX_ROWS        = 1024,
	parameter int MAX_HALF_LENGTH = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	fsmask_item_if.sink       items,
	fsmask_verdict_if.source  verdicts,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	logic     q_push, q_full, q_pop, q_empty;
	cmd_t     push_cmd, q_head;
	logic     emit, init_busy, out_free;
	verdict_t emit_verdict;

	logic       out_valid_q;
	logic [1:0] verdict_q;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols <= 11'd640;
			cfg_q.rows <= 11'd480;
			cfg_q.half <= 5'd5;
			cfg_q.margin <= 9'd0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_COLUMNS: cfg_q.cols <= pwdata[10:0];
				REG_ROWS: cfg_q.rows <= pwdata[10:0];
				REG_HALF: cfg_q.half <= pwdata[4:0];
				REG_MARGIN: cfg_q.margin <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_COLUMNS: prdata = DATA_W'(cfg_q.cols);
			REG_ROWS: prdata = DATA_W'(cfg_q.rows);
			REG_HALF: prdata = DATA_W'(cfg_q.half);
			REG_MARGIN: prdata = DATA_W'(cfg_q.margin);
			default: prdata = '0;
		endcase
	end

	fsmask_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS),
		.MAX_HALF_LENGTH(MAX_HALF_LENGTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.hold(init_busy),
		.items(items),
		.cfg(cfg_q),
		.q_full(q_full),
		.push(q_push),
		.push_cmd(push_cmd)
	);

	fsmask_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(q_pop),
		.head(q_head),
		.empty(q_empty)
	);

	fsmask_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.out_free(out_free),
		.emit(emit),
		.emit_verdict(emit_verdict),
		.init_busy(init_busy)
	);

	// Verdict register decouples the back from the taker.
	assign out_free = !out_valid_q || verdicts.ready;
	assign verdicts.valid = out_valid_q;
	assign verdicts.verdict = verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) verdict_q <= emit_verdict;
	end

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("verdict issued while the verdict register is still held");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !q_pop |=> !(q_push && q_full && !q_pop) || q_full)
		else $error("command queue overflow");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("front pushed into a full queue");

	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		!init_busy |=> !init_busy)
		else $error("reset clear sweep restarted without reset");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back popped an empty queue");

endmodule

[test/feature_spacing_mask_check.sv]
`timescale 1ns / 100ps
// Occupancy-mask verdict predictor and in-order verdict scoreboard for feature_spacing_mask.
module feature_spacing_mask_check import fsmask_pkg::*; #(
	parameter int MAX_COLUMNS     = 1024,
	parameter int MAX_ROWS        = 1024,
	parameter int MAX_HALF_LENGTH = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	fsmask_item_if            items,
	fsmask_verdict_if         verdicts,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	output int                mismatches,
	output int                pending
);

	bit [MAX_COLUMNS-1:0] occupied [MAX_ROWS];
	logic [10:0]          cols_reg;
	logic [10:0]          rows_reg;
	logic [4:0]           half_reg;
	logic [8:0]           margin_reg;
	verdict_t             verdicts_due [$];
	verdict_t             due;

	function automatic void wipe_mask();
		foreach (occupied[r])
			occupied[r] = '0;
	endfunction

	function automatic int eff_cols();
		if (cols_reg == 0)
			return 1;
		return (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_reg);
	endfunction

	function automatic int eff_rows();
		if (rows_reg == 0)
			return 1;
		return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	// q4 to whole pixels, halves away from zero
	function automatic int to_pixel(logic signed [14:0] q);
		int v;
		v = q;
		if (v >= 0)
			return (v + 8) / 16;
		return -((8 - v) / 16);
	endfunction

	function automatic void mark_square(int px, int py);
		int h, c0, c1, r0, r1, r, c;
		h  = (half_reg > MAX_HALF_LENGTH) ? MAX_HALF_LENGTH : int'(half_reg);
		c0 = (px - h < 0) ? 0 : px - h;
		r0 = (py - h < 0) ? 0 : py - h;
		c1 = (px + h > eff_cols() - 1) ? eff_cols() - 1 : px + h;
		r1 = (py + h > eff_rows() - 1) ? eff_rows() - 1 : py + h;
		for (r = r0; r <= r1; r++)
			for (c = c0; c <= c1; c++)
				occupied[r][c] = 1'b1;
	endfunction

	function automatic verdict_t predict_verdict(kind_t op, logic signed [14:0] xq,
			logic signed [14:0] yq);
		int px, py, lo, xmax, ymax;
		px   = to_pixel(xq);
		py   = to_pixel(yq);
		lo   = margin_reg;
		xmax = eff_cols() - lo - 1;
		ymax = eff_rows() - lo - 1;
		case (op)
			KIND_CLEAR: begin
				wipe_mask();
				return VERDICT_DONE;
			end
			KIND_OLD: begin
				mark_square(px, py);
				return VERDICT_DONE;
			end
			KIND_CAND: begin
				if (px < lo || px > xmax || py < lo || py > ymax)
					return VERDICT_BORDER;
				if (occupied[py][px])
					return VERDICT_BLOCKED;
				mark_square(px, py);
				return VERDICT_ACCEPT;
			end
			default: return VERDICT_DONE;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_reg   = 11'd640;
			rows_reg   = 11'd480;
			half_reg   = 5'd5;
			margin_reg = 9'd0;
			wipe_mask();
			verdicts_due.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_COLUMNS: cols_reg   = pwdata[10:0];
					REG_ROWS:    rows_reg   = pwdata[10:0];
					REG_HALF:    half_reg   = pwdata[4:0];
					REG_MARGIN:  margin_reg = pwdata[8:0];
					default: ;
				endcase
			end
			// a verdict always comes after its item, so compare before adding
			if (verdicts.valid && verdicts.ready) begin
				if (verdicts_due.size() == 0) begin
					$error("verdict: expected none, got %0d", verdicts.verdict);
					mismatches <= mismatches + 1;
				end else begin
					due = verdicts_due.pop_front();
					if (verdicts.verdict !== due) begin
						$error("verdict: expected %0d, got %0d", due, verdicts.verdict);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (items.valid && items.ready)
				verdicts_due.insert(verdicts_due.size(),
					predict_verdict(kind_t'(items.kind), items.x_q4, items.y_q4));
			pending <= verdicts_due.size();
		end
	end

endmodule

[test/feature_spacing_mask_test.sv]
`timescale 1ns / 100ps
// Stimulus, clock, reset and final verdict for the feature_spacing_mask testbench.
module feature_spacing_mask_test;
	import fsmask_pkg::*;

	localparam int MAX_COLUMNS     = 1024;
	localparam int MAX_ROWS        = 1024;
	localparam int MAX_HALF_LENGTH = 31;
	localparam int GAP_MAX         = 18;
	// a frame clear sweeps the whole mask, one word per cycle
	localparam int SETTLE_CYCLES   = MAX_ROWS * ((MAX_COLUMNS + 63) / 64) + 256;
	localparam int TAIL_CYCLES     = 200;
	localparam int HOLD_AFTER      = 400;
	localparam int HOLD_CYCLES     = 600;
	localparam int LIMIT_CYCLES    = 4_000_000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                mismatches;
	int                pending;
	int                cycles = 0;
	int                offered = 0;
	int                send_mode = 1;
	int                take_mode = 1;
	int                cols_now = 640;
	int                rows_now = 480;
	int                half_now = 5;
	int                last_x = 0;
	int                last_y = 0;

	fsmask_item_if    items();
	fsmask_verdict_if verdicts();

	feature_spacing_mask #(
		.MAX_COLUMNS    (MAX_COLUMNS),
		.MAX_ROWS       (MAX_ROWS),
		.MAX_HALF_LENGTH(MAX_HALF_LENGTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.verdicts(verdicts),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	feature_spacing_mask_check #(
		.MAX_COLUMNS    (MAX_COLUMNS),
		.MAX_ROWS       (MAX_ROWS),
		.MAX_HALF_LENGTH(MAX_HALF_LENGTH)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.verdicts  (verdicts),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("feature_spacing_mask: mismatch");
			$finish;
		end
	end

	function automatic logic [14:0] to_q4(int v);
		if (v > 16383)
			v = 16383;
		if (v < -16384)
			v = -16384;
		return v[14:0];
	endfunction

	function automatic int extent_of(int size, int limit);
		if (size == 0)
			return 0;
		return (size > limit) ? limit - 1 : size - 1;
	endfunction

	// mostly in or just around the image, some near the last candidate, some anywhere
	function automatic int pick_coord(int extent, int last);
		int span, p;
		span = half_now + 2;
		p = int'($urandom_range(0, extent + 3)) - 2;
		case ($urandom_range(0, 9))
			0: return int'($urandom_range(0, 32767)) - 16384;
			1, 2, 3: p = last / 16 + int'($urandom_range(0, 2 * span)) - span;
			default: ;
		endcase
		return p * 16 + int'($urandom_range(0, 15)) - 8;
	endfunction

	task automatic send_item(kind_t op, int xq, int yq);
		int gap;
		if (offered % 50 == 0)
			send_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
		offered++;
		gap = (send_mode == 0) ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid <= 1'b1;
		items.kind  <= op;
		items.x_q4  <= to_q4(xq);
		items.y_q4  <= to_q4(yq);
		do @(posedge clk); while (!items.ready);
	endtask

	task automatic apb_write(reg_idx_t idx, int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// only once every verdict is back and a trailing clear sweep has had time to finish
	task automatic load_config(int c, int r, int h, int m);
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_write(REG_COLUMNS, c);
		apb_write(REG_ROWS, r);
		apb_write(REG_HALF, h);
		apb_write(REG_MARGIN, m);
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		cols_now = c;
		rows_now = r;
		half_now = h;
	endtask

	// frames: a clear, then old features and candidates; a few unused kinds mixed in
	task automatic run_frames(int count, bit fresh);
		int frame_left, x, y, roll, ext_x, ext_y;
		ext_x = extent_of(cols_now, MAX_COLUMNS);
		ext_y = extent_of(rows_now, MAX_ROWS);
		frame_left = fresh ? 0 : $urandom_range(10, 60);
		repeat (count) begin
			if (frame_left == 0) begin
				send_item(KIND_CLEAR, int'($urandom_range(0, 32767)) - 16384,
					int'($urandom_range(0, 32767)) - 16384);
				frame_left = $urandom_range(40, 90);
			end else begin
				roll = $urandom_range(0, 99);
				x = pick_coord(ext_x, last_x);
				y = pick_coord(ext_y, last_y);
				if (roll < 12)
					send_item(KIND_OLD, x, y);
				else if (roll < 96) begin
					send_item(KIND_CAND, x, y);
					last_x = x;
					last_y = y;
				end else
					send_item(KIND_NONE, x, y);
				frame_left--;
			end
		end
		items.valid <= 1'b0;
	endtask

	initial begin
		int stall, taken;
		taken = 0;
		verdicts.ready = 1'b0;
		forever begin
			if (taken % 64 == 0)
				take_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
			stall = (take_mode == 0) ? 0 : $urandom_range(0, GAP_MAX);
			// one long hold-off so the block backs up into its item input
			if (taken == HOLD_AFTER)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				verdicts.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			verdicts.ready <= 1'b1;
			do @(posedge clk); while (!verdicts.valid);
			taken++;
		end
	end

	initial begin
		arst_n      = 1'b0;
		items.valid = 1'b0;
		items.kind  = KIND_CLEAR;
		items.x_q4  = '0;
		items.y_q4  = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset settings 640x480, half 5, margin 0
		send_item(KIND_CAND, 0, 0);
		send_item(KIND_CAND, 0, 0);
		send_item(KIND_CAND, -8, 0);
		send_item(KIND_CAND, -7, 7);
		send_item(KIND_CAND, 24, 200);
		send_item(KIND_OLD, 1600, 1600);
		send_item(KIND_CAND, 103 * 16, 1600);
		send_item(KIND_CAND, 106 * 16, 1600);
		send_item(KIND_CAND, 639 * 16, 479 * 16);
		send_item(KIND_CAND, 640 * 16, 100 * 16);
		send_item(KIND_CAND, 100 * 16, 480 * 16);
		send_item(KIND_CAND, 16383, 16383);
		send_item(KIND_CAND, -16384, -16384);
		send_item(KIND_OLD, -16384, 16383);
		send_item(KIND_OLD, 16383, -16384);
		send_item(KIND_OLD, 2 * 16, 3 * 16);
		send_item(KIND_CAND, 4 * 16 + 8, 8);
		send_item(KIND_NONE, 16383, -16384);
		send_item(KIND_NONE, 0, 0);
		send_item(KIND_CLEAR, 0, 0);
		send_item(KIND_CAND, 0, 0);
		send_item(KIND_CAND, 300 * 16 - 8, 200 * 16 + 7);
		send_item(KIND_CAND, 300 * 16 + 9, 200 * 16);
		send_item(KIND_CAND, -16, 300);

		run_frames(250, 1'b0);
		load_config(1, 1, 0, 0);
		run_frames(150, 1'b1);
		// zero sizes act as one; mask left over from the previous size stays
		load_config(0, 0, 31, 0);
		run_frames(150, 1'b0);
		load_config(1024, 1024, 31, 511);
		run_frames(200, 1'b1);
		load_config(2047, 2047, 17, 3);
		run_frames(250, 1'b0);
		load_config(64, 48, 2, 4);
		run_frames(250, 1'b1);
		// margin wider than half the width: nothing fits
		load_config(100, 90, 7, 60);
		run_frames(100, 1'b0);
		repeat (3) begin
			load_config($urandom_range(1, 1024), $urandom_range(1, 1024),
				$urandom_range(0, 31), $urandom_range(0, 40));
			run_frames(120, $urandom_range(0, 1));
		end

		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("feature_spacing_mask: match");
		else
			$display("feature_spacing_mask: mismatch");
		$finish;
	end

endmodule
